// ----- design/bclp_pkg.sv -----
// Package of the brace command line parser: character codes, record and
// result types, status codes and the small divide-by-100 helper.
// No dependencies; every design file but bclp_ifs imports it.
`timescale 1ns / 1ps
`default_nettype none

package bclp_pkg;

	// A field of this many characters or more marks the line as truncated.
	localparam logic [4:0] FIELD_CHARS = 5'd16;

	// Character codes of the command stream.
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_PRINT_LO  = 8'h20;
	localparam logic [7:0] CH_PRINT_HI  = 8'h7E;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_COMMA     = 8'h2C;
	localparam logic [7:0] CH_COLON     = 8'h3A;
	localparam logic [7:0] CH_SEMI      = 8'h3B;
	localparam logic [7:0] CH_OPEN      = 8'h7B;
	localparam logic [7:0] CH_CLOSE     = 8'h7D;
	localparam logic [7:0] CH_PLUS      = 8'h2B;
	localparam logic [7:0] CH_MINUS     = 8'h2D;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_NINE      = 8'h39;

	// Command letters, seven bits wide as stored in the record.
	localparam logic [6:0] CMD_NONE     = 7'h00;
	localparam logic [6:0] CMD_S_UP     = 7'h53;
	localparam logic [6:0] CMD_S_LO     = 7'h73;
	localparam logic [6:0] CMD_R_UP     = 7'h52;
	localparam logic [6:0] CMD_R_LO     = 7'h72;
	localparam logic [6:0] CMD_U_LO     = 7'h75;
	localparam logic [6:0] CMD_E_LO     = 7'h65;
	localparam logic [6:0] CMD_X_LO     = 7'h78;
	localparam logic [6:0] CMD_BRACKET  = 7'h5D;
	localparam logic [6:0] CMD_BRACE    = 7'h7D;

	// Line status codes.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_EMPTY     = 3'd1;
	localparam logic [2:0] ST_NO_CMD    = 3'd2;
	localparam logic [2:0] ST_SHORT_S   = 3'd3;
	localparam logic [2:0] ST_SHORT_R   = 3'd4;
	localparam logic [2:0] ST_SHORT_U   = 3'd5;
	localparam logic [2:0] ST_SHORT_E   = 3'd6;
	localparam logic [2:0] ST_TRUNC     = 3'd7;

	// Record defaults and the fixed connector numbers of the 'x' layout.
	localparam logic [15:0] NODE_LOCAL  = 16'd2;
	localparam logic [15:0] CONN_ID_X   = 16'd98;
	localparam logic [15:0] CONN_VAL_X  = 16'd99;
	localparam logic [2:0]  FIELD_MAX   = 3'd7;

	// Packed node/id numbers are split by this base.
	localparam int unsigned PACK_BASE   = 100;

	// The magnitude accumulator saturates here; its split is known up front.
	localparam longint unsigned SAT_MAG = 64'h8000_0000;
	localparam logic [35:0] SAT_MAG36   = 36'(SAT_MAG);
	localparam logic [31:0] SAT_MAG32   = 32'(SAT_MAG);
	localparam logic [15:0] SAT_Q_LOW   = 16'(SAT_MAG / PACK_BASE);
	localparam logic [6:0]  SAT_R       = 7'(SAT_MAG % PACK_BASE);
	// A positive saturated field reads as 0x7FFFFFFF, one below SAT_MAG.
	localparam logic [6:0]  SAT_R_POS   = 7'((SAT_MAG - 1) % PACK_BASE);
	localparam logic [31:0] POS_MAX     = 32'h7FFF_FFFF;

	typedef enum logic [2:0] {
		CLS_DROP,
		CLS_OPEN,
		CLS_SEP,
		CLS_END,
		CLS_TEXT
	} cls_t;

	// State of the field being collected, as the record logic sees it.
	typedef struct packed {
		logic [4:0]  char_cnt;
		logic [6:0]  first_char;
		logic [31:0] value;
		logic [15:0] node_q;
		logic [7:0]  id_r;
	} field_t;

	typedef struct packed {
		logic [6:0]  cmd;
		logic [15:0] node;
		logic [7:0]  id;
		logic [15:0] conn;
		logic [31:0] val;
		logic [15:0] delta;
	} rec_t;

	typedef struct packed {
		logic [2:0]  status;
		rec_t        rec;
		logic [2:0]  total;
	} res_t;

	function automatic cls_t classify(input logic [7:0] c);
		cls_t k;
		if (c == CH_CR || c == CH_CLOSE) begin
			k = CLS_END;
		end else if (c < CH_PRINT_LO || c > CH_PRINT_HI) begin
			k = CLS_DROP;
		end else if (c == CH_OPEN) begin
			k = CLS_OPEN;
		end else if (c == CH_SEMI || c == CH_COMMA || c == CH_COLON || c == CH_SPACE) begin
			k = CLS_SEP;
		end else begin
			k = CLS_TEXT;
		end
		return k;
	endfunction

	// Quotient by 100 of a value below 1000, by nine parallel compares.
	function automatic logic [3:0] div100(input logic [9:0] t);
		logic [3:0] q;
		q = '0;
		for (int k = 1; k <= 9; k++) begin
			if (t >= 10'(k * PACK_BASE)) begin
				q = q + 4'd1;
			end
		end
		return q;
	endfunction

endpackage

`default_nettype wire

// ----- design/bclp_ifs.sv -----
// Channel interfaces of the brace command line parser: character input,
// configuration write and result record output. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface bclp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	modport source (output valid, output char_in, input ready);
	modport sink (input valid, input char_in, output ready);
endinterface

interface bclp_cfg_if;
	logic valid;
	logic ready;
	logic dialect;
	modport source (output valid, output dialect, input ready);
	modport sink (input valid, input dialect, output ready);
endinterface

interface bclp_rec_if;
	logic               valid;
	logic               ready;
	logic        [2:0]  status;
	logic        [6:0]  command;
	logic signed [15:0] node_num;
	logic        [7:0]  item_id;
	logic signed [15:0] conn_num;
	logic signed [31:0] value_out;
	logic        [15:0] delta_time;
	logic        [2:0]  field_total;
	modport source (output valid, output status, output command, output node_num,
		output item_id, output conn_num, output value_out, output delta_time,
		output field_total, input ready);
	modport sink (input valid, input status, input command, input node_num,
		input item_id, input conn_num, input value_out, input delta_time,
		input field_total, output ready);
endinterface

`default_nettype wire

// ----- design/bclp_field_acc.sv -----
// Per-field number accumulator: sign, saturating decimal magnitude and the
// running quotient and remainder by 100. Depends on bclp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bclp_field_acc import bclp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic       clear,
	input  logic [7:0] c,
	output field_t     field
);

	logic [4:0]  ci_q;
	logic [6:0]  fc_q;
	logic [31:0] mag_q;
	logic        neg_q;
	logic        de_q;
	logic [15:0] quot_q;
	logic [6:0]  rem_q;

	logic        digit;
	logic [3:0]  d;
	logic [35:0] nm;
	logic        sat;
	logic [9:0]  t;
	logic [3:0]  tq;
	logic [6:0]  tr;
	logic [6:0]  rem_rd;

	assign digit = (c >= CH_ZERO) && (c <= CH_NINE);
	assign d     = c[3:0];
	assign nm    = 36'({mag_q, 3'b000}) + 36'({mag_q, 1'b0}) + 36'(d);
	assign sat   = nm > SAT_MAG36;
	assign t     = {rem_q, 3'b000} + 10'({rem_q, 1'b0}) + 10'(d);
	assign tq    = div100(t);
	assign tr    = 7'(t - 10'(tq) * 10'(PACK_BASE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ci_q   <= '0;
			fc_q   <= '0;
			mag_q  <= '0;
			neg_q  <= 1'b0;
			de_q   <= 1'b0;
			quot_q <= '0;
			rem_q  <= '0;
		end else if (clear) begin
			ci_q   <= '0;
			fc_q   <= '0;
			mag_q  <= '0;
			neg_q  <= 1'b0;
			de_q   <= 1'b0;
			quot_q <= '0;
			rem_q  <= '0;
		end else if (take) begin
			if (ci_q == '0) begin
				fc_q <= c[6:0];
				if (c == CH_MINUS || c == CH_PLUS) begin
					neg_q <= (c == CH_MINUS);
				end else if (!digit) begin
					de_q <= 1'b1;
				end
			end else if (!digit) begin
				de_q <= 1'b1;
			end
			// A digit never sets the end mark, so the old mark decides.
			if (digit && !de_q) begin
				if (sat) begin
					mag_q  <= SAT_MAG32;
					quot_q <= SAT_Q_LOW;
					rem_q  <= SAT_R;
				end else begin
					mag_q  <= nm[31:0];
					quot_q <= 16'({quot_q, 3'b000}) + 16'({quot_q, 1'b0}) + 16'(tq);
					rem_q  <= tr;
				end
			end
			if (ci_q != 5'd31) begin
				ci_q <= ci_q + 5'd1;
			end
		end
	end

	// Only the saturated magnitude has bit 31 set; read positive it is 0x7FFFFFFF.
	assign rem_rd = (!neg_q && mag_q[31]) ? SAT_R_POS : rem_q;

	always_comb begin
		field.char_cnt   = ci_q;
		field.first_char = fc_q;
		if (neg_q) begin
			field.value  = ~mag_q + 32'd1;
			field.node_q = ~quot_q + 16'd1;
			field.id_r   = ~{1'b0, rem_rd} + 8'd1;
		end else begin
			field.value  = mag_q[31] ? POS_MAX : mag_q;
			field.node_q = quot_q;
			field.id_r   = {1'b0, rem_rd};
		end
	end

endmodule

`default_nettype wire

// ----- design/bclp_record.sv -----
// Record assembler: counts fields, places each closed field by command form
// and dialect, and forms the line result with its status. Depends on bclp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bclp_record import bclp_pkg::*; #(
	parameter logic [4:0] FIELD_LEN = FIELD_CHARS
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   step,
	input  cls_t   cls,
	input  field_t field,
	input  logic   dialect,
	output logic   emit,
	output res_t   res
);

	logic [2:0] fidx_q;
	logic       old_q;
	logic       trunc_q;
	rec_t       rec_q;

	logic [2:0] fidx_n;
	logic       trunc_n;
	logic       old_n;
	logic       special;
	rec_t       rec_n;
	logic [2:0] status;

	assign fidx_n  = (fidx_q == FIELD_MAX) ? FIELD_MAX : fidx_q + 3'd1;
	assign trunc_n = trunc_q || (field.char_cnt >= FIELD_LEN);
	assign special = dialect ? (rec_q.cmd == CMD_X_LO) : (rec_q.cmd == CMD_S_LO);

	always_comb begin
		rec_n = rec_q;
		old_n = old_q;
		case (fidx_n)
			3'd1: begin
				rec_n.cmd = (field.char_cnt != '0) ? field.first_char : CMD_NONE;
				old_n = (rec_n.cmd == CMD_S_LO) || (rec_n.cmd == CMD_R_LO) ||
					(rec_n.cmd == CMD_U_LO) || (rec_n.cmd == CMD_E_LO);
			end
			3'd2: begin
				if (special) begin
					if (dialect) begin
						rec_n.conn = CONN_ID_X;
					end
					rec_n.id = field.value[7:0];
				end else if (!old_q) begin
					rec_n.node = field.value[15:0];
				end else begin
					rec_n.node = field.node_q;
					rec_n.id   = field.id_r;
				end
			end
			3'd3: begin
				if (special) begin
					if (dialect) begin
						rec_n.conn = CONN_VAL_X;
					end
					rec_n.val = field.value;
				end else if (!old_q) begin
					rec_n.id = field.value[7:0];
				end else begin
					rec_n.conn = field.value[15:0];
				end
			end
			3'd4: begin
				if (!old_q) begin
					rec_n.conn = field.value[15:0];
				end else begin
					rec_n.val = field.value;
				end
			end
			3'd5: begin
				if (!old_q) begin
					rec_n.val = field.value;
				end else begin
					rec_n.delta = field.value[15:0];
				end
			end
			3'd6: begin
				if (!old_q) begin
					rec_n.delta = field.value[15:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (trunc_n) begin
			status = ST_TRUNC;
		end else begin
			case (rec_n.cmd) inside
				CMD_NONE:              status = ST_NO_CMD;
				CMD_BRACE, CMD_BRACKET: status = ST_EMPTY;
				CMD_S_UP, CMD_S_LO:    status = (fidx_n < 3'd4) ? ST_SHORT_S : ST_OK;
				CMD_R_UP, CMD_R_LO:    status = (fidx_n < 3'd2) ? ST_SHORT_R : ST_OK;
				CMD_U_LO:              status = (fidx_n < 3'd4) ? ST_SHORT_U : ST_OK;
				CMD_E_LO:              status = (fidx_n < 3'd4) ? ST_SHORT_E : ST_OK;
				default:               status = ST_OK;
			endcase
		end
	end

	assign emit       = step && (cls == CLS_END);
	assign res.status = status;
	assign res.rec    = rec_n;
	assign res.total  = fidx_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fidx_q  <= '0;
			old_q   <= 1'b0;
			trunc_q <= 1'b0;
			rec_q   <= '{cmd: CMD_NONE, node: NODE_LOCAL, default: '0};
		end else if (step) begin
			unique case (cls)
				CLS_OPEN: begin
					fidx_q <= '0;
				end
				CLS_SEP: begin
					fidx_q  <= fidx_n;
					old_q   <= old_n;
					trunc_q <= trunc_n;
					rec_q   <= rec_n;
				end
				CLS_END: begin
					fidx_q  <= '0;
					old_q   <= 1'b0;
					trunc_q <= 1'b0;
					rec_q   <= '{cmd: CMD_NONE, node: NODE_LOCAL, default: '0};
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- design/brace_command_line_parser.sv -----
// Top level of the brace command line parser: input stage, field and
// record logic, result register. Depends on bclp_pkg, bclp_ifs, submodules.
//
//   channel   dir   payload                                       beat when
//   chars     in    char_in[7:0]                                  valid && ready
//   cfg       in    dialect                                       valid && ready
//   records   out   status command node_num item_id conn_num      valid && ready
//                   value_out delta_time field_total
//
// One character is taken per cycle while the result register is empty or being
// drained; each beat waits in the input register, and its result, if any, is
// written to the result register as the parser steps. The rate is set by the
// record and accumulator step, which updates all parser state per beat.
// Reset (arst_n low) clears the parser to an empty record with the 's' dialect.
// While a finished record waits, the input register still takes a beat; the
// character held there waits until the record is taken.
`timescale 1ns / 1ps
`default_nettype none

module brace_command_line_parser import bclp_pkg::*; #(
	// A field of this many characters or more marks its line as truncated.
	parameter logic [4:0] FIELD_LEN = FIELD_CHARS
) (
	input  logic         clk,
	input  logic         arst_n,
	bclp_char_if.sink    chars,
	bclp_cfg_if.sink     cfg,
	bclp_rec_if.source   records
);

	// Input register: one character beat waiting for the parser step.
	logic       valid_s1;
	logic [7:0] char_s1;

	logic       dialect_q;
	logic       out_valid_q;
	res_t       out_q;

	logic       advance;
	cls_t       cls;
	field_t     field;
	logic       emit;
	res_t       res;

	// The held character is processed once the result register can take
	// whatever it produces, that is when it is empty or being drained.
	assign advance     = valid_s1 && (!out_valid_q || records.ready);
	assign chars.ready = !valid_s1 || advance;
	assign cls         = classify(char_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_in;
		end
	end

	// The dialect register accepts a write in every cycle.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dialect_q <= 1'b0;
		end else if (cfg.valid) begin
			dialect_q <= cfg.dialect;
		end
	end

	bclp_field_acc u_field_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (advance && (cls == CLS_TEXT)),
		.clear  (advance && (cls == CLS_OPEN || cls == CLS_SEP || cls == CLS_END)),
		.c      (char_s1),
		.field  (field)
	);

	bclp_record #(
		.FIELD_LEN (FIELD_LEN)
	) u_record (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.cls     (cls),
		.field   (field),
		.dialect (dialect_q),
		.emit    (emit),
		.res     (res)
	);

	// Result register: a new record may replace one that is taken this cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (records.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
	end

	assign records.valid       = out_valid_q;
	assign records.status      = out_q.status;
	assign records.command     = out_q.rec.cmd;
	assign records.node_num    = out_q.rec.node;
	assign records.item_id     = out_q.rec.id;
	assign records.conn_num    = out_q.rec.conn;
	assign records.value_out   = out_q.rec.val;
	assign records.delta_time  = out_q.rec.delta;
	assign records.field_total = out_q.total;

endmodule

`default_nettype wire

// ----- design/bclp_checker.sv -----
// Port-level checker of the brace command line parser and its bind to the
// top level. Depends on bclp_pkg and brace_command_line_parser.
`timescale 1ns / 1ps
`default_nettype none

module bclp_checker import bclp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [6:0]  command,
	input logic [31:0] value_out,
	input logic [2:0]  field_total
);

	// A record beat that is not taken stays offered unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(command) && $stable(value_out))
		else $error("record beat changed while stalled");

	// The line end (closing brace or CR) always closes a field, so a line has at least one.
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> field_total != 3'd0)
		else $error("record with no closed field");

	// An empty first field reads as no command unless truncation wins.
	a_no_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && command == CMD_NONE |-> status == ST_NO_CMD || status == ST_TRUNC)
		else $error("missing command not flagged");

	// The empty-command status belongs only to the bracket commands.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> command == CMD_BRACKET || command == CMD_BRACE)
		else $error("empty status with another command");

endmodule

bind brace_command_line_parser bclp_checker u_bclp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (records.valid),
	.out_ready   (records.ready),
	.status      (records.status),
	.command     (records.command),
	.value_out   (records.value_out),
	.field_total (records.field_total)
);

`default_nettype wire
